FILE: hw/rtl/setx_pkg.sv
// ----------------------------------------------------------------------------
// setx_pkg
// Shared types and constants for the sprite entry tile expander.
// ----------------------------------------------------------------------------
`default_nettype none

package setx_pkg;

    localparam int PRIO_W   = 2;
    localparam int WORD_W   = 16;
    localparam int COORD_W  = 17;
    localparam int TILE_W   = 17;
    localparam int SIZE_W   = 2;
    localparam int COLOR_W  = 4;
    localparam int PAL_W    = 8;
    localparam int IDX_W    = 3;
    localparam int OFF_W    = 2 * IDX_W;
    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = 1;
    localparam int Q_CNT_W  = 2;

    localparam logic [WORD_W-1:0] ATTR_FLIP_X  = 16'h0001;
    localparam logic [WORD_W-1:0] ATTR_FLIP_Y  = 16'h0002;
    localparam logic [WORD_W-1:0] ATTR_ENABLE  = 16'h0004;
    localparam int                ATTR_PRIO_LO = 4;
    localparam int                SC_COLOR_LO  = 4;
    localparam logic [PAL_W-1:0]  PAL_BASE     = 8'h80;

    typedef struct packed {
        logic [WORD_W-1:0] attr_word;
        logic [WORD_W-1:0] code_word;
        logic [WORD_W-1:0] size_color_word;
        logic [WORD_W-1:0] pos_y;
        logic [WORD_W-1:0] pos_x;
    } entry_t;

    typedef struct packed {
        logic [TILE_W-1:0]  tile_number;
        logic [COORD_W-1:0] tile_x;
        logic [COORD_W-1:0] tile_y;
        logic [PAL_W-1:0]   palette_index;
        logic               mirror_x;
        logic               mirror_y;
        logic               last_tile;
    } tile_t;

    typedef struct packed {
        logic [WORD_W-1:0]  code;
        logic [WORD_W-1:0]  pos_x;
        logic [WORD_W-1:0]  pos_y;
        logic [SIZE_W-1:0]  size_log;
        logic [COLOR_W-1:0] color;
        logic               flip_x;
        logic               flip_y;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [IDX_W-1:0] size_mask(input logic [SIZE_W-1:0] size_log);
        logic [IDX_W-1:0] m;
        case (size_log)
            2'd0:    m = 3'd0;
            2'd1:    m = 3'd1;
            2'd2:    m = 3'd3;
            default: m = 3'd7;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/setx_front.sv
// ----------------------------------------------------------------------------
// setx_front
// Accepts sprite entries, checks enable and priority class, queues jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module setx_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [setx_pkg::PRIO_W-1:0] cfg_wdata,
    input  wire logic                       entry_valid,
    output logic                            entry_stall,
    input  wire setx_pkg::entry_t           entry,
    input  wire setx_pkg::q_status_t        q_status,
    output logic                            push,
    output setx_pkg::job_t                  job
);
    import setx_pkg::*;

    logic [PRIO_W-1:0] priority_select_reg;
    logic [PRIO_W-1:0] priority_select_next;
    logic              accept;
    logic              keep;

    always_comb
    begin
        priority_select_next = cfg_we ? cfg_wdata : priority_select_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            priority_select_reg <= '0;
        end
        else
        begin
            priority_select_reg <= priority_select_next;
        end
    end

    assign entry_stall = q_status.full;
    assign accept      = entry_valid && !entry_stall;
    assign keep        = ((entry.attr_word & ATTR_ENABLE) != '0) &&
                         (entry.attr_word[ATTR_PRIO_LO +: PRIO_W] == priority_select_reg);
    assign push        = accept && keep;

    always_comb
    begin
        job.code     = entry.code_word;
        job.pos_x    = entry.pos_x;
        job.pos_y    = entry.pos_y;
        job.size_log = entry.size_color_word[SIZE_W-1:0];
        job.color    = entry.size_color_word[SC_COLOR_LO +: COLOR_W];
        job.flip_x   = (entry.attr_word & ATTR_FLIP_X) != '0;
        job.flip_y   = (entry.attr_word & ATTR_FLIP_Y) != '0;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/setx_queue.sv
// ----------------------------------------------------------------------------
// setx_queue
// Short job queue between the classifier and the tile sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module setx_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire setx_pkg::job_t      push_job,
    input  wire logic                pop,
    output setx_pkg::job_t           pop_job,
    output setx_pkg::q_status_t      q_status
);
    import setx_pkg::*;

    job_t               slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               do_push;
    logic               do_pop;

    assign q_status.full  = count_reg == Q_CNT_W'(Q_DEPTH);
    assign q_status.empty = count_reg == '0;
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign pop_job        = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/setx_back.sv
// ----------------------------------------------------------------------------
// setx_back
// Walks a sprite's tiles, registering one tile request a cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module setx_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire setx_pkg::q_status_t q_status,
    input  wire setx_pkg::job_t      pop_job,
    output logic                     pop,
    output logic                     tile_valid,
    input  wire logic                tile_stall,
    output setx_pkg::tile_t          tile
);
    import setx_pkg::*;

    job_t             job_reg;
    job_t             job_next;
    logic             busy_reg;
    logic             busy_next;
    logic [IDX_W-1:0] col_reg;
    logic [IDX_W-1:0] col_next;
    logic [IDX_W-1:0] row_reg;
    logic [IDX_W-1:0] row_next;
    logic             tile_valid_reg;
    logic             tile_valid_next;
    tile_t            tile_reg;
    tile_t            tile_next;

    logic             out_free;
    logic             advance;
    logic [IDX_W-1:0] mask;
    logic             last_col;
    logic             last;
    logic [IDX_W-1:0] c;
    logic [IDX_W-1:0] r;
    logic [OFF_W-1:0] offset;
    tile_t            cur;

    assign out_free = !tile_valid_reg || !tile_stall;
    assign advance  = busy_reg && out_free;
    assign pop      = !busy_reg && !q_status.empty;
    assign mask     = size_mask(job_reg.size_log);
    assign last_col = col_reg == mask;
    assign last     = last_col && (row_reg == mask);
    assign c        = job_reg.flip_x ? (mask - col_reg) : col_reg;
    assign r        = job_reg.flip_y ? (mask - row_reg) : row_reg;
    assign offset   = {row_reg[2], col_reg[2], row_reg[1], col_reg[1], row_reg[0], col_reg[0]};

    always_comb
    begin
        cur.tile_number   = {1'b0, job_reg.code} + TILE_W'(offset);
        cur.tile_x        = {1'b0, job_reg.pos_x} + COORD_W'({c, 3'b000});
        cur.tile_y        = {1'b0, job_reg.pos_y} + COORD_W'({r, 3'b000});
        cur.palette_index = PAL_BASE | PAL_W'(job_reg.color);
        cur.mirror_x      = job_reg.flip_x;
        cur.mirror_y      = job_reg.flip_y;
        cur.last_tile     = last;
    end

    always_comb
    begin
        job_next        = pop ? pop_job : job_reg;
        busy_next       = busy_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        tile_next       = advance ? cur : tile_reg;
        tile_valid_next = tile_valid_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            col_next  = '0;
            row_next  = '0;
        end
        else if (advance)
        begin
            if (last)
            begin
                busy_next = 1'b0;
            end
            col_next = last_col ? '0 : col_reg + 1'b1;
            row_next = last_col ? row_reg + 1'b1 : row_reg;
        end
        if (advance)
        begin
            tile_valid_next = 1'b1;
        end
        else if (!tile_stall)
        begin
            tile_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            col_reg        <= '0;
            row_reg        <= '0;
            tile_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            tile_valid_reg <= tile_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        tile_reg <= tile_next;
    end

    assign tile_valid = tile_valid_reg;
    assign tile       = tile_reg;

`ifndef SYNTH
    a_grid_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (col_reg <= mask) && (row_reg <= mask))
        else $error("tile counter beyond sprite size");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && last) |=> !busy_reg && tile_reg.last_tile && tile_valid_reg)
        else $error("sprite did not end on its last tile");

    a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> busy_reg && (col_reg == '0) && (row_reg == '0))
        else $error("job start did not clear the tile counters");

    a_not_last_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !last) |=> busy_reg && !tile_reg.last_tile)
        else $error("last tile flagged inside a sprite");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/sprite_entry_tile_expander_unit.sv
// ----------------------------------------------------------------------------
// sprite_entry_tile_expander_unit
// Expands sprite entries of one priority class into 8x8 tile draw requests.
// ----------------------------------------------------------------------------
// Entry channel (entry_valid / entry_stall / entry) takes one five-word
// sprite entry per request. Disabled entries, and entries whose priority
// class differs from the value last written on cfg_we / cfg_wdata, are
// consumed and produce nothing.
// A kept entry goes into a two-deep job queue. The tile sequencer pops a job
// and then issues size*size tile requests, row-major, on the tile channel
// (tile_valid / tile_stall / tile), one per cycle unless tile_stall holds
// them; last_tile marks the final one. The sequencer takes the next job only
// once the last tile of its sprite is registered. An entry passes the queue,
// job and tile output registers before its first tile appears.
// The entry side stalls only while the queue is full, so entries keep
// flowing while the tile receiver stalls, up to two jobs ahead.
// A stalled tile request holds in the output register; the walk pauses.
// Reset clears the queue, the sequencer, the output valid and sets the
// priority class to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_entry_tile_expander_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [setx_pkg::PRIO_W-1:0] cfg_wdata,
    input  wire logic                        entry_valid,
    output logic                             entry_stall,
    input  wire setx_pkg::entry_t            entry,
    output logic                             tile_valid,
    input  wire logic                        tile_stall,
    output setx_pkg::tile_t                  tile
);
    import setx_pkg::*;

    q_status_t q_status;
    logic      push;
    logic      pop;
    job_t      push_job;
    job_t      pop_job;

    setx_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .entry_valid (entry_valid),
        .entry_stall (entry_stall),
        .entry       (entry),
        .q_status    (q_status),
        .push        (push),
        .job         (push_job)
    );

    setx_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .q_status (q_status)
    );

    setx_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .pop_job    (pop_job),
        .pop        (pop),
        .tile_valid (tile_valid),
        .tile_stall (tile_stall),
        .tile       (tile)
    );

endmodule

`default_nettype wire

FILE: sim/tb_sprite_entry_tile_expander_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sprite_entry_tile_expander_unit
// Drives sprite entries into the expander under several priority classes and
// predicts every 8x8 tile request from the entry words: tile number with the
// interleaved layout offset, mirrored positions, palette line and last flag.
// Tiles are checked in order against the prediction while both sides idle at
// random, save in a last calm phase; directed extremes precede random entries.
// ----------------------------------------------------------------------------

module tb_sprite_entry_tile_expander_unit;

    import setx_pkg::*;

    localparam int STUCK_LIMIT  = 2000;
    localparam int REPORT_LIMIT = 10;
    localparam int PHASE_ITEMS  = 64;

    class tile_scoreboard;
        logic [PRIO_W-1:0] prio_class;
        tile_t             expected_tiles[$];
        int                mismatches;

        function new();
            prio_class = '0;
            mismatches = 0;
        endfunction

        function void set_class(logic [PRIO_W-1:0] cls);
            prio_class = cls;
        endfunction

        function int pending();
            return expected_tiles.size();
        endfunction

        function void note_entry(entry_t e);
            int          side;
            int          c;
            int          r;
            logic [2:0]  rb;
            logic [2:0]  cb;
            logic [OFF_W-1:0] offset;
            tile_t       t;
            if ((e.attr_word & ATTR_ENABLE) == '0)
                return;
            if (e.attr_word[ATTR_PRIO_LO +: PRIO_W] != prio_class)
                return;
            side = 1 << e.size_color_word[SIZE_W-1:0];
            for (int row = 0; row < side; row++)
            begin
                for (int col = 0; col < side; col++)
                begin
                    rb = row[2:0];
                    cb = col[2:0];
                    for (int b = 0; b < IDX_W; b++)
                    begin
                        offset[2*b]     = cb[b];
                        offset[2*b + 1] = rb[b];
                    end
                    c = e.attr_word[0] ? side - 1 - col : col;
                    r = e.attr_word[1] ? side - 1 - row : row;
                    t.tile_number   = TILE_W'(e.code_word) + TILE_W'(offset);
                    t.tile_x        = COORD_W'(e.pos_x) + COORD_W'(8 * c);
                    t.tile_y        = COORD_W'(e.pos_y) + COORD_W'(8 * r);
                    t.palette_index = PAL_BASE | PAL_W'(e.size_color_word[SC_COLOR_LO +: COLOR_W]);
                    t.mirror_x      = e.attr_word[0];
                    t.mirror_y      = e.attr_word[1];
                    t.last_tile     = (row == side - 1) && (col == side - 1);
                    expected_tiles.push_back(t);
                end
            end
        endfunction

        function void check_tile(tile_t got);
            tile_t exp;
            bit    bad;
            if (expected_tiles.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected tile request: num=%h x=%h y=%h pal=%h mx=%b my=%b last=%b",
                             got.tile_number, got.tile_x, got.tile_y, got.palette_index,
                             got.mirror_x, got.mirror_y, got.last_tile);
                return;
            end
            exp = expected_tiles.pop_front();
            bad = (got.tile_number !== exp.tile_number) || (got.tile_x !== exp.tile_x)
               || (got.tile_y !== exp.tile_y) || (got.palette_index !== exp.palette_index)
               || (got.mirror_x !== exp.mirror_x) || (got.mirror_y !== exp.mirror_y)
               || (got.last_tile !== exp.last_tile);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("tile mismatch expected: num=%h x=%h y=%h pal=%h mx=%b my=%b last=%b",
                             exp.tile_number, exp.tile_x, exp.tile_y, exp.palette_index,
                             exp.mirror_x, exp.mirror_y, exp.last_tile);
                    $display("               actual: num=%h x=%h y=%h pal=%h mx=%b my=%b last=%b",
                             got.tile_number, got.tile_x, got.tile_y, got.palette_index,
                             got.mirror_x, got.mirror_y, got.last_tile);
                end
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [PRIO_W-1:0] cfg_wdata;
    logic              entry_valid;
    logic              entry_stall;
    entry_t            entry;
    logic              tile_valid;
    logic              tile_stall;
    tile_t             tile;

    tile_scoreboard    sb;
    bit                calm;

    sprite_entry_tile_expander_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .entry_valid (entry_valid),
        .entry_stall (entry_stall),
        .entry       (entry),
        .tile_valid  (tile_valid),
        .tile_stall  (tile_stall),
        .tile        (tile)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // check each accepted tile request
    always @(posedge clk)
    begin
        if (rst_n && tile_valid && !tile_stall)
            sb.check_tile(tile);
    end

    // tile receiver backpressure in bursts
    initial
    begin : tile_backpressure
        int  n;
        bit  hold;
        tile_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                hold = 1'b1;
                n    = $urandom_range(1, 19);
            end
            else
            begin
                hold = 1'b0;
                n    = $urandom_range(1, 30);
            end
            repeat (n)
            begin
                @(negedge clk);
                tile_stall <= hold;
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((entry_valid && !entry_stall) || (tile_valid && !tile_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_sprite_entry_tile_expander_unit failed");
        $finish;
    end

    task automatic write_priority(input logic [PRIO_W-1:0] cls);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cls;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_class(cls);
    endtask

    task automatic send_entry(input entry_t e);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            entry_valid <= 1'b0;
        end
        @(negedge clk);
        entry_valid <= 1'b1;
        entry       <= e;
        do
            @(posedge clk);
        while (entry_stall);
        sb.note_entry(e);
    endtask

    // drop valid, wait out every expected tile and let dropped entries retire
    task automatic drain_requests();
        @(negedge clk);
        entry_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic entry_t random_entry(input logic [PRIO_W-1:0] cls);
        entry_t e;
        int     k;
        e.attr_word       = 16'($urandom);
        e.code_word       = 16'($urandom);
        e.size_color_word = 16'($urandom);
        e.pos_y           = 16'($urandom);
        e.pos_x           = 16'($urandom);
        if ($urandom_range(0, 3) != 0)
        begin
            e.attr_word = e.attr_word | ATTR_ENABLE;
            e.attr_word[ATTR_PRIO_LO +: PRIO_W] = cls;
        end
        k = $urandom_range(0, 99);
        e.size_color_word[SIZE_W-1:0] = (k < 30) ? 2'd0 : (k < 60) ? 2'd1 : (k < 88) ? 2'd2 : 2'd3;
        return e;
    endfunction

    initial
    begin : stimulus
        logic [PRIO_W-1:0] phase_class[5];
        sb          = new();
        calm        = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        entry_valid = 1'b0;
        entry       = '0;
        phase_class = '{2'd3, 2'd1, 2'd2, 2'd0, 2'd3};
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        write_priority(2'd0);
        send_entry({16'h0004, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
        send_entry({16'h0005, 16'h1234, 16'h0011, 16'h0010, 16'h0020});
        send_entry({16'h0006, 16'h00ff, 16'h00a2, 16'h0100, 16'h0200});
        send_entry({16'h0007, 16'hffff, 16'h00f3, 16'hffff, 16'hffff});
        send_entry({16'h0004, 16'hffc0, 16'h0003, 16'hfff8, 16'hfff8});
        send_entry({16'h0000, 16'h5555, 16'h0003, 16'h0001, 16'h0001});
        send_entry({16'hfffb, 16'haaaa, 16'hffff, 16'hffff, 16'hffff});
        send_entry({16'h0014, 16'h0001, 16'h0002, 16'h0002, 16'h0002});
        send_entry({16'h0034, 16'h0002, 16'h0001, 16'h0003, 16'h0003});
        send_entry({16'hffcf, 16'h7fff, 16'h0052, 16'h8000, 16'h8000});
        send_entry({16'h0004, 16'h8000, 16'hff0d, 16'h00ff, 16'h0f0f});
        send_entry({16'h0005, 16'h0040, 16'h00fc, 16'h0000, 16'hffff});
        drain_requests();

        for (int p = 0; p < 5; p++)
        begin
            if (p == 4)
                calm = 1'b1;
            write_priority(phase_class[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_entry(random_entry(phase_class[p]));
            drain_requests();
        end

        repeat (70) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_sprite_entry_tile_expander_unit passed");
        else
            $display("tb_sprite_entry_tile_expander_unit failed");
        $finish;
    end

endmodule
